@@ rtl/core/rsm_pkg.sv @@
`default_nettype none

package rsm_pkg;

    // Row geometry
    localparam int MAX_COLS       = 64;
    localparam int COL_IDX_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int COUNT_W        = $clog2(MAX_COLS + 1);

    // Exponent datapath
    localparam int EXP_TABLE_BITS = 8;
    localparam int EXP_DEPTH      = 2 ** EXP_TABLE_BITS;
    localparam int LOGIT_W        = 16;
    localparam int PROB_W         = 16;
    localparam int FRAC_W         = 17;
    localparam int T_W            = 33;
    localparam int N_W            = T_W - 24;
    localparam int SUM_W          = 23;
    localparam int RECIP_W        = 32;
    localparam int PROD_W         = PROB_W + RECIP_W;
    localparam int DIV_STEPS      = RECIP_W + 1;
    localparam int STEP_W         = $clog2(DIV_STEPS);
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam int MAX_SHIFT      = 17;

    // 2^(-2^-k) in Q0.32
    localparam logic [31:0] ROOT_CONSTS [10] = '{
        32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
        32'd4202935003, 32'd4248701965, 32'd4271771997, 32'd4283353945,
        32'd4289156600, 32'd4292061010
    };

    typedef logic [FRAC_W-1:0] frac_tab_t [EXP_DEPTH];

    // Fraction table 2^(-idx/2^B) in Q1.16, built at elaboration
    function automatic frac_tab_t build_frac_table();
        frac_tab_t   tab;
        logic [63:0] acc;
        logic [63:0] sum;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            acc = 64'd1 << 31;
            for (int k = 1; k <= EXP_TABLE_BITS; k++) begin
                if (((i >> (EXP_TABLE_BITS - k)) & 1) != 0) begin
                    acc = ((acc * {32'd0, ROOT_CONSTS[k-1]}) + (64'd1 << 31)) >> 32;
                end
            end
            sum = (acc + (64'd1 << 14)) >> 15;
            tab[i] = sum[FRAC_W-1:0];
        end
        return tab;
    endfunction

    localparam frac_tab_t FRAC_TABLE = build_frac_table();

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit;
        logic                      last;
    } element_t;

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic              end_of_row;
        logic              row_truncated;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]        count;
        logic signed [LOGIT_W-1:0] max;
        logic                      ovf;
    } row_desc_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [PROB_W-1:0] value;
    } exp_beat_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SUM,
        B_DIV,
        B_EMIT
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/rsm_ram.sv @@
`default_nettype none

module rsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/rsm_front.sv @@
`default_nettype none

module rsm_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire rsm_pkg::element_t             element,
    output logic                               ram_we,
    output logic [rsm_pkg::COL_IDX_W-1:0]      ram_waddr,
    output logic [rsm_pkg::LOGIT_W-1:0]        ram_wdata,
    output logic                               push,
    output rsm_pkg::row_desc_t                 push_desc
);
    import rsm_pkg::*;

    logic [COUNT_W-1:0]        count_reg, count_next;
    logic signed [LOGIT_W-1:0] max_reg, max_next;
    logic                      ovf_reg, ovf_next;
    logic                      accept;
    logic                      room;
    logic [COUNT_W-1:0]        count_upd;
    logic signed [LOGIT_W-1:0] max_upd;
    logic                      ovf_upd;

    assign accept = start & ~busy;
    assign room   = count_reg < COUNT_W'(MAX_COLS);

    // Store the beat while there is room, track max and drop flag
    always_comb
    begin
        count_upd = room ? count_reg + COUNT_W'(1) : count_reg;
        max_upd   = (room && (element.logit > max_reg)) ? element.logit : max_reg;
        ovf_upd   = ovf_reg | ~room;

        count_next = count_reg;
        max_next   = max_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (element.last)
            begin
                count_next = '0;
                max_next   = {1'b1, {(LOGIT_W-1){1'b0}}};
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = count_upd;
                max_next   = max_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    assign ram_we          = accept & room;
    assign ram_waddr       = count_reg[COL_IDX_W-1:0];
    assign ram_wdata       = element.logit;
    assign push            = accept & element.last;
    assign push_desc.count = count_upd;
    assign push_desc.max   = max_upd;
    assign push_desc.ovf   = ovf_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= {1'b1, {(LOGIT_W-1){1'b0}}};
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            max_reg   <= max_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rsm_queue.sv @@
`default_nettype none

module rsm_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rsm_pkg::row_desc_t push_desc,
    input  wire logic               pop,
    output rsm_pkg::row_desc_t      head,
    output logic                    not_empty
);
    import rsm_pkg::*;

    row_desc_t   entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;

    // Two-entry row descriptor queue
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = fill_reg != 2'd0;

endmodule

`default_nettype wire

@@ rtl/core/rsm_exp.sv @@
`default_nettype none

module rsm_exp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_last,
    input  wire logic [rsm_pkg::LOGIT_W-1:0]  x,
    input  wire logic [rsm_pkg::LOGIT_W-1:0]  max,
    output rsm_pkg::exp_beat_t                out
);
    import rsm_pkg::*;

    logic               v1_reg, l1_reg;
    logic [T_W-1:0]     t_reg, t_next;
    logic [LOGIT_W-1:0] d;
    exp_beat_t          out_next;
    logic               out_valid_reg;
    logic               out_last_reg;
    logic [PROB_W-1:0]  out_value_reg;
    logic [N_W-1:0]     n;
    logic [FRAC_W-1:0]  v;
    logic [4:0]         sh;
    logic [FRAC_W:0]    rnd;
    logic [FRAC_W:0]    shifted;

    // Stage 1: (max - x) * log2(e)
    always_comb
    begin
        d      = max - x;
        t_next = T_W'(d) * T_W'(LOG2E_Q16);
    end

    // Stage 2: fraction lookup, shift by integer part, saturate
    always_comb
    begin
        n       = t_reg[T_W-1:24];
        v       = FRAC_TABLE[t_reg[23:24-EXP_TABLE_BITS]];
        sh      = n[4:0];
        rnd     = (FRAC_W+1)'(1) << (sh - 5'd1);
        shifted = ({1'b0, v} + rnd) >> sh;
        if (n > N_W'(MAX_SHIFT))
        begin
            shifted = '0;
        end
        else if (n == '0)
        begin
            shifted = {1'b0, v};
        end
        out_next.valid = v1_reg;
        out_next.last  = l1_reg;
        out_next.value = (shifted > (FRAC_W+1)'(16'hFFFF)) ? 16'hFFFF
                                                           : shifted[PROB_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        l1_reg        <= in_last;
        out_last_reg  <= out_next.last;
        out_value_reg <= out_next.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= in_valid;
            out_valid_reg <= out_next.valid;
        end
    end

    assign out = {out_valid_reg, out_last_reg, out_value_reg};

endmodule

`default_nettype wire

@@ rtl/core/rsm_back.sv @@
`default_nettype none

module rsm_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          desc_avail,
    input  wire rsm_pkg::row_desc_t            head,
    output logic                               pop,
    output logic [rsm_pkg::COL_IDX_W-1:0]      ram_raddr,
    input  wire logic [rsm_pkg::LOGIT_W-1:0]   ram_rdata,
    output logic                               active,
    output logic                               result_valid,
    output rsm_pkg::result_t                   result
);
    import rsm_pkg::*;

    back_state_t          state_reg, state_next;
    row_desc_t            desc_reg, desc_next;
    logic [COUNT_W-1:0]   issue_reg, issue_next;
    logic                 rdv_reg, rdl_reg;
    logic                 issuing;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [RECIP_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [SUM_W:0]       trial;
    logic                 pv_reg, pv_next;
    logic                 pl_reg;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [PROD_W-1:0]    rounded;
    logic                 rv_reg;
    result_t              res_reg, res_next;
    exp_beat_t            eb;

    rsm_exp u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rdv_reg),
        .in_last  (rdl_reg),
        .x        (ram_rdata),
        .max      (desc_reg.max),
        .out      (eb)
    );

    // Buffer walk, shared by the sum pass and the emit pass
    assign issuing   = ((state_reg == B_SUM) || (state_reg == B_EMIT))
                       && (issue_reg < desc_reg.count);
    assign ram_raddr = issue_reg[COL_IDX_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        desc_next  = desc_reg;
        issue_next = issuing ? issue_reg + COUNT_W'(1) : issue_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        trial      = {rem_reg, (step_reg == '0)};
        unique case (state_reg)
            B_IDLE:
            begin
                if (desc_avail)
                begin
                    pop        = 1'b1;
                    desc_next  = head;
                    issue_next = '0;
                    sum_next   = '0;
                    state_next = B_SUM;
                end
            end
            B_SUM:
            begin
                if (eb.valid)
                begin
                    sum_next = sum_reg + SUM_W'(eb.value);
                    if (eb.last)
                    begin
                        rem_next   = '0;
                        quo_next   = '0;
                        step_next  = '0;
                        state_next = B_DIV;
                    end
                end
            end
            B_DIV:
            begin
                // restoring divide of 2^32 by the sum, one bit per cycle
                if (trial >= {1'b0, sum_reg})
                begin
                    rem_next = SUM_W'(trial - {1'b0, sum_reg});
                    quo_next = {quo_reg[RECIP_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[SUM_W-1:0];
                    quo_next = {quo_reg[RECIP_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    if (sum_reg == '0)
                    begin
                        quo_next = '0;
                    end
                    issue_next = '0;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (pv_reg && pl_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Scale by the reciprocal, round and saturate
    always_comb
    begin
        pv_next   = eb.valid && (state_reg == B_EMIT);
        prod_next = PROD_W'(eb.value) * PROD_W'(quo_reg);
        rounded   = (prod_reg + PROD_W'(1 << 15)) >> 16;
        res_next.probability   = (rounded > PROD_W'(16'hFFFF)) ? 16'hFFFF
                                                               : rounded[PROB_W-1:0];
        res_next.end_of_row    = pl_reg;
        res_next.row_truncated = desc_reg.ovf;
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        rdl_reg  <= (issue_reg == desc_reg.count - COUNT_W'(1));
        prod_reg <= prod_next;
        pl_reg   <= eb.last;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            issue_reg <= '0;
            step_reg  <= '0;
            rdv_reg   <= 1'b0;
            pv_reg    <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            step_reg  <= step_next;
            rdv_reg   <= issuing;
            pv_reg    <= pv_next;
            rv_reg    <= pv_reg;
        end
    end

    assign active       = state_reg != B_IDLE;
    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/row_softmax.sv @@
`default_nettype none

// Row softmax over signed Q8.8 logits, unsigned Q0.16 probabilities.
// Input: one beat per element on element (logit, last), taken on a clock
// edge with start high and busy low. Up to MAX_COLS elements are kept;
// further ones are dropped and the row's results carry row_truncated.
// The beat marked last closes the row; busy then stays high until the
// row's final result has gone out.
// Output: one beat per stored element, in arrival order, on result with
// result_valid high for one cycle; end_of_row marks the final one. The
// receiver cannot stall, so every beat must be taken when shown.
// Processing: after loading, a row takes one buffer walk through the exp
// pipeline to build the sum, a bit-serial reciprocal division, and a
// second walk that rescales and emits one beat per cycle. Both walks
// share the single buffer read port.
// Reset clears the row state and pending work; buffer contents are not
// cleared since only entries of the current row are read.
module row_softmax (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rsm_pkg::element_t  element,
    output logic                    result_valid,
    output rsm_pkg::result_t        result
);
    import rsm_pkg::*;

    logic                 ram_we;
    logic [COL_IDX_W-1:0] ram_waddr;
    logic [LOGIT_W-1:0]   ram_wdata;
    logic [COL_IDX_W-1:0] ram_raddr;
    logic [LOGIT_W-1:0]   ram_rdata;
    logic                 push;
    row_desc_t            push_desc;
    logic                 pop;
    row_desc_t            head;
    logic                 not_empty;
    logic                 back_active;

    // Hold off input while a row waits or is being worked on
    assign busy = not_empty | back_active;

    rsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .element   (element),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .push      (push),
        .push_desc (push_desc)
    );

    rsm_ram #(
        .WIDTH (LOGIT_W),
        .DEPTH (MAX_COLS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    rsm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc_avail   (not_empty),
        .head         (head),
        .pop          (pop),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .active       (back_active),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
